// ===== design/u16u8_pkg.sv =====
// Shared types, constants and the UTF-8 sequence encoder for the UTF-16 to UTF-8 transcoder.
`default_nettype none

package u16u8_pkg;

  // Most bytes that one code unit can cause: a flushed lone surrogate plus a BMP character.
  localparam int unsigned MAX_RUN = 6;
  localparam int unsigned RUN_CNT_W = $clog2(MAX_RUN + 1);

  localparam logic [15:0] SURR_MASK = 16'hFC00;
  localparam logic [15:0] HIGH_SURR = 16'hD800;
  localparam logic [15:0] LOW_SURR = 16'hDC00;
  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [5:0] HIGH_TAG = 6'b110110;

  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD4 = 8'hF0;
  localparam logic [7:0] CONT = 8'h80;
  localparam logic [7:0] NUL_BYTE = 8'h00;

  // One encoded code point: bytes in send order (lead first) and its length.
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0] len;
  } seq_t;

  // The bytes caused by one accepted code unit.
  typedef struct packed {
    logic [MAX_RUN-1:0][7:0] data;
    logic [RUN_CNT_W-1:0] cnt;
  } run_t;

  // Standard UTF-8 encoding of a 21-bit code point.
  function automatic seq_t encode(input logic [20:0] cp);
    seq_t s;
    s.data = '0;
    if (cp < 21'h80) begin
      s.len = 3'd1;
      s.data[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      s.len = 3'd2;
      s.data[0] = LEAD2 | {3'b000, cp[10:6]};
      s.data[1] = CONT | {2'b00, cp[5:0]};
    end else if (cp < SUPP_BASE) begin
      s.len = 3'd3;
      s.data[0] = LEAD3 | {4'b0000, cp[15:12]};
      s.data[1] = CONT | {2'b00, cp[11:6]};
      s.data[2] = CONT | {2'b00, cp[5:0]};
    end else begin
      s.len = 3'd4;
      s.data[0] = LEAD4 | {5'b00000, cp[20:18]};
      s.data[1] = CONT | {2'b00, cp[17:12]};
      s.data[2] = CONT | {2'b00, cp[11:6]};
      s.data[3] = CONT | {2'b00, cp[5:0]};
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== design/u16u8_decode.sv =====
// Input stage: surrogate pairing, byte budget and encoding of one code unit into a byte run.
`default_nettype none

module u16u8_decode (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [15:0]       in_code_unit,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [15:0]       cfg_output_capacity,
  output logic                   run_valid,
  input  wire logic              run_ready,
  output u16u8_pkg::run_t        run
);
  import u16u8_pkg::*;

  logic [15:0] capacity_r, capacity_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [9:0]  held_r, held_nxt;
  logic        held_valid_r, held_valid_nxt;
  logic        exh_r, exh_nxt;

  logic        accept;
  logic        is_zero, u_low, u_high;
  logic [20:0] held_cp, pair_cp, a_cp;
  seq_t        seq_a, seq_b;
  logic        fit_a, emit_a, exh1, fresh, try_b, fit_b, emit_b;
  logic [15:0] bl1;
  logic [2:0]  na, nb;

  assign cfg_ready = 1'b1;
  assign in_ready  = run_ready;
  assign run_valid = in_valid;
  assign accept    = in_valid && in_ready;

  // Classify the incoming unit.
  assign is_zero = (in_code_unit == 16'h0000);
  assign u_low   = ((in_code_unit & SURR_MASK) == LOW_SURR);
  assign u_high  = ((in_code_unit & SURR_MASK) == HIGH_SURR);

  // First sequence: the held high surrogate, alone or paired with this low surrogate.
  assign held_cp = {5'd0, HIGH_TAG, held_r};
  assign pair_cp = SUPP_BASE + {1'b0, held_r, in_code_unit[9:0]};
  assign a_cp    = (!is_zero && u_low) ? pair_cp : held_cp;
  assign seq_a   = encode(a_cp);
  assign fit_a   = ({13'd0, seq_a.len} < bytes_left_r);
  assign emit_a  = held_valid_r && !exh_r && fit_a;
  assign exh1    = exh_r || (held_valid_r && !fit_a);
  assign bl1     = emit_a ? (bytes_left_r - {13'd0, seq_a.len}) : bytes_left_r;

  // Second sequence: the terminator byte or the unit itself.
  always_comb begin
    if (is_zero) begin
      seq_b = '0;
      seq_b.data[0] = NUL_BYTE;
      seq_b.len = 3'd1;
    end else begin
      seq_b = encode({5'd0, in_code_unit});
    end
  end

  assign fresh  = !is_zero && !(held_valid_r && u_low);
  assign try_b  = fresh && !exh1 && !u_high;
  assign fit_b  = ({13'd0, seq_b.len} < bl1);
  assign emit_b = is_zero || (try_b && fit_b);
  assign na     = emit_a ? seq_a.len : 3'd0;
  assign nb     = emit_b ? seq_b.len : 3'd0;

  // Pack both sequences into one run, the second right after the first.
  always_comb begin
    logic [2:0] k;
    k = 3'd0;
    run.cnt = RUN_CNT_W'(na + nb);
    for (int i = 0; i < MAX_RUN; i++) begin
      if (3'(i) < na) begin
        run.data[i] = seq_a.data[i[1:0]];
      end else begin
        k = 3'(i) - na;
        run.data[i] = (k < 3'd4) ? seq_b.data[k[1:0]] : NUL_BYTE;
      end
    end
  end

  // Next state of the budget and surrogate holder.
  always_comb begin
    capacity_nxt   = capacity_r;
    bytes_left_nxt = bytes_left_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    exh_nxt        = exh_r;
    if (cfg_valid && cfg_ready) begin
      capacity_nxt   = cfg_output_capacity;
      bytes_left_nxt = cfg_output_capacity;
      exh_nxt        = 1'b0;
    end else if (accept) begin
      if (is_zero) begin
        held_valid_nxt = 1'b0;
        bytes_left_nxt = capacity_r;
        exh_nxt        = 1'b0;
      end else begin
        held_valid_nxt = fresh && !exh1 && u_high;
        if (fresh && !exh1 && u_high) begin
          held_nxt = in_code_unit[9:0];
        end
        exh_nxt        = exh1 || (try_b && !fit_b);
        bytes_left_nxt = (try_b && fit_b) ? (bl1 - {13'd0, seq_b.len}) : bl1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r   <= 16'hFFFF;
      bytes_left_r <= 16'hFFFF;
      held_r       <= 10'd0;
      held_valid_r <= 1'b0;
      exh_r        <= 1'b0;
    end else begin
      capacity_r   <= capacity_nxt;
      bytes_left_r <= bytes_left_nxt;
      held_r       <= held_nxt;
      held_valid_r <= held_valid_nxt;
      exh_r        <= exh_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/u16u8_serial.sv =====
// Output stage: holds one byte run and sends it one byte per beat through an output register.
`default_nettype none

module u16u8_serial (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              run_valid,
  output logic                   run_ready,
  input  wire u16u8_pkg::run_t   run,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_last_in_run
);
  import u16u8_pkg::*;

  run_t                 run_r, run_nxt;
  logic                 run_valid_r, run_valid_nxt;
  logic [RUN_CNT_W-1:0] idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_byte_r, out_byte_nxt;
  logic                 out_last_r, out_last_nxt;

  logic out_free, move, at_last;

  assign out_free  = !out_valid_r || out_ready;
  assign move      = run_valid_r && out_free;
  assign at_last   = (idx_r == run_r.cnt - RUN_CNT_W'(1));
  assign run_ready = !run_valid_r || (move && at_last);

  // Step through the held run and refill it from the input stage.
  always_comb begin
    run_nxt       = run_r;
    run_valid_nxt = run_valid_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (move) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = run_r.data[idx_r];
      out_last_nxt  = at_last;
      idx_nxt       = idx_r + RUN_CNT_W'(1);
      if (at_last) begin
        run_valid_nxt = 1'b0;
        idx_nxt       = '0;
      end
    end
    if (run_valid && run_ready && (run.cnt != '0)) begin
      run_nxt       = run;
      run_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      run_valid_r <= run_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    run_r      <= run_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_in_run = out_last_r;

endmodule

`default_nettype wire

// ===== design/utf16_to_utf8_transcoder_core.sv =====
// Top level of the UTF-16 to UTF-8 transcoder: input stage feeding the byte serializer.
//
// Usage: UTF-16 code units enter on the in_ channel (valid/ready), UTF-8 bytes leave on
// the out_ channel, one byte per beat, with out_last_in_run high on the final byte
// caused by a unit. A code unit of zero ends a string and always yields a NUL byte.
// cfg_output_capacity sets the per-string byte budget; write it only while idle.
// cfg_ready is always high.
// Path: with the serializer idle, a unit's first byte goes into the held run register
// and then into the output register.
// Throughput: one output byte per cycle while out_ready is high; a unit causes up to
// six bytes, and a held surrogate or a dropped unit causes none and loads no run.
// The next unit is taken in the same cycle as the last byte of the current run moves
// into the output register.
// Reset: synchronous, active low; the budget reloads to 65535 and no surrogate is held.
// Stall: while out_ready is low the output byte holds, one run waits in the serializer
// and in_ready drops until that run drains.
`default_nettype none

module utf16_to_utf8_transcoder_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_code_unit,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_output_capacity,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last_in_run
);
  import u16u8_pkg::*;

  run_t run;
  logic run_valid;
  logic run_ready;

  u16u8_decode u_decode (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_code_unit        (in_code_unit),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_output_capacity (cfg_output_capacity),
    .run_valid           (run_valid),
    .run_ready           (run_ready),
    .run                 (run)
  );

  u16u8_serial u_serial (
    .clk             (clk),
    .rst_n           (rst_n),
    .run_valid       (run_valid),
    .run_ready       (run_ready),
    .run             (run),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_in_run (out_last_in_run)
  );

endmodule

`default_nettype wire

// ===== verif/utf16_to_utf8_transcoder_core_tb.sv =====
// Self-checking testbench for the UTF-16 to UTF-8 transcoder core.
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder_core_tb;
  import u16u8_pkg::*;

  localparam int DIR_ROWS = 25;
  localparam int N_PHASES = 8;
  localparam int CAP_RANDOM = -1;
  localparam int LONG_HOLD = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 4;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_t;

  // One expected output beat.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } utf8_beat_t;

  // One directed row: optional capacity write, the code unit, and typed bytes (lead first).
  typedef struct packed {
    logic        set_cap;
    logic [15:0] cap;
    logic [15:0] unit;
    logic        typed;
    logic [2:0]  n;
    logic [47:0] bytes;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_code_unit = 16'h0000;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_output_capacity = 16'h0000;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last_in_run;

  // Predictor state of the transcoder.
  logic [15:0] cap_reg = 16'hFFFF;
  logic [15:0] bytes_left = 16'hFFFF;
  logic [9:0]  held_bits = 10'd0;
  logic        held_v = 1'b0;
  logic        exhausted = 1'b0;
  logic [7:0]  run_bytes [0:5];
  int          run_len;

  utf8_beat_t  utf8_expected [$];
  utf8_beat_t  exp_beat;
  stim_row_t   dir_tab [0:DIR_ROWS-1];

  int          errors = 0;
  int          n_checked = 0;
  int          n_units = 0;
  int          n_effective = 0;
  int          n_cfg = 0;
  logic        tx_idle = 1'b0;
  logic        rx_stall = 1'b0;
  int          idle_pct = 63;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  int          phase_cap [0:N_PHASES-1] = '{65535, 12, 0, 65535, 7, 1, CAP_RANDOM, 65535};
  idle_mode_t  phase_mode [0:N_PHASES-1] = '{IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_RX,
                                             IDLE_BOTH, IDLE_TX, IDLE_NONE, IDLE_BOTH};
  int          phase_goal [0:N_PHASES-1] = '{30, 20, 12, 25, 20, 12, 20, 16};

  utf16_to_utf8_transcoder_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_code_unit        (in_code_unit),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_output_capacity (cfg_output_capacity),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_byte            (out_byte),
    .out_last_in_run     (out_last_in_run)
  );

  // Free-running clock, 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void add_run_byte(input logic [7:0] b);
    run_bytes[run_len] = b;
    run_len++;
  endfunction

  // Encodes one code point into the current run, subject to the byte budget.
  function automatic void append_code_point(input logic [20:0] cp);
    int n;
    if (exhausted)
      return;
    if (cp < 21'h80)
      n = 1;
    else if (cp < 21'h800)
      n = 2;
    else if (cp < SUPP_BASE)
      n = 3;
    else
      n = 4;
    if (n >= bytes_left) begin
      exhausted = 1'b1;
      return;
    end
    bytes_left = bytes_left - 16'(n);
    case (n)
      1: add_run_byte(cp[7:0]);
      2: begin
        add_run_byte(LEAD2 | {3'b000, cp[10:6]});
        add_run_byte(CONT | {2'b00, cp[5:0]});
      end
      3: begin
        add_run_byte(LEAD3 | {4'b0000, cp[15:12]});
        add_run_byte(CONT | {2'b00, cp[11:6]});
        add_run_byte(CONT | {2'b00, cp[5:0]});
      end
      default: begin
        add_run_byte(LEAD4 | {5'b00000, cp[20:18]});
        add_run_byte(CONT | {2'b00, cp[17:12]});
        add_run_byte(CONT | {2'b00, cp[11:6]});
        add_run_byte(CONT | {2'b00, cp[5:0]});
      end
    endcase
  endfunction

  // Works out the bytes that one accepted code unit causes.
  function automatic void transcode_unit(input logic [15:0] u);
    logic        fresh;
    logic [15:0] held_unit;
    run_len = 0;
    fresh = 1'b1;
    held_unit = HIGH_SURR | {6'd0, held_bits};
    if (u == 16'h0000) begin
      // The terminator flushes a held surrogate and always yields NUL.
      if (held_v)
        append_code_point({5'd0, held_unit});
      held_v = 1'b0;
      add_run_byte(NUL_BYTE);
      bytes_left = cap_reg;
      exhausted = 1'b0;
      fresh = 1'b0;
    end else if (held_v) begin
      held_v = 1'b0;
      if ((u & SURR_MASK) == LOW_SURR) begin
        append_code_point(SUPP_BASE + {1'b0, held_bits, u[9:0]});
        fresh = 1'b0;
      end else begin
        append_code_point({5'd0, held_unit});
      end
    end
    if (fresh && !exhausted) begin
      if ((u & SURR_MASK) == HIGH_SURR) begin
        held_bits = u[9:0];
        held_v = 1'b1;
      end else begin
        append_code_point({5'd0, u});
      end
    end
  endfunction

  // Offers one code unit, waits for its beat, then queues the bytes it should cause.
  task automatic send_unit(input logic [15:0] unit, input logic use_typed,
                           input int typed_len, input logic [47:0] typed_bytes);
    int         i;
    utf8_beat_t beat;
    while (tx_idle && ($urandom_range(0, 99) < idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_code_unit <= unit;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    transcode_unit(unit);
    if (use_typed) begin
      for (i = 0; i < typed_len; i++) begin
        beat.data = typed_bytes[47 - 8*i -: 8];
        beat.last = (i == typed_len - 1);
        utf8_expected.push_back(beat);
      end
    end else begin
      for (i = 0; i < run_len; i++) begin
        beat.data = run_bytes[i];
        beat.last = (i == run_len - 1);
        utf8_expected.push_back(beat);
      end
    end
    if (run_len != 0 || held_v)
      n_effective++;
    n_units++;
  endtask

  // Stops offering and waits until every expected byte has come, then lets the outputs settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (utf8_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] value);
    cfg_valid           <= 1'b1;
    cfg_output_capacity <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cap_reg    = value;
    bytes_left = value;
    exhausted  = 1'b0;
    cfg_valid <= 1'b0;
    n_cfg++;
  endtask

  // Receiver: random stalls per phase, plus one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (rx_stall) begin
      out_ready <= ($urandom_range(0, 99) >= idle_pct);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compares each output beat with the oldest expected byte.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (utf8_expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual byte %02h last %0b",
                 $time, out_byte, out_last_in_run);
      end else begin
        exp_beat = utf8_expected.pop_front();
        n_checked++;
        if (out_byte !== exp_beat.data) begin
          errors++;
          $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                   $time, exp_beat.data, out_byte);
        end
        if (out_last_in_run !== exp_beat.last) begin
          errors++;
          $display("%0t: out_last_in_run mismatch, expected %0b, actual %0b",
                   $time, exp_beat.last, out_last_in_run);
        end
      end
    end
  end

  // Watchdog: ends the run when no beat moves on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: timeout, no beat for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // Main stimulus: directed table, then random phases over several capacities.
  initial begin : stimulus
    int          r;
    int          p;
    int          k;
    int          start;
    int          pick;
    logic [15:0] u;
    logic [15:0] cap_val;

    // Directed rows; bytes are typed in except where a held surrogate is flushed.
    dir_tab[0]  = '{1'b0, 16'd0, 16'h0000, 1'b1, 3'd1, 48'h00_00_00_00_00_00};
    dir_tab[1]  = '{1'b0, 16'd0, 16'h007F, 1'b1, 3'd1, 48'h7F_00_00_00_00_00};
    dir_tab[2]  = '{1'b0, 16'd0, 16'h0080, 1'b1, 3'd2, 48'hC2_80_00_00_00_00};
    dir_tab[3]  = '{1'b0, 16'd0, 16'h07FF, 1'b1, 3'd2, 48'hDF_BF_00_00_00_00};
    dir_tab[4]  = '{1'b0, 16'd0, 16'h0800, 1'b1, 3'd3, 48'hE0_A0_80_00_00_00};
    dir_tab[5]  = '{1'b0, 16'd0, 16'hFFFF, 1'b1, 3'd3, 48'hEF_BF_BF_00_00_00};
    dir_tab[6]  = '{1'b0, 16'd0, 16'hD800, 1'b1, 3'd0, 48'h00_00_00_00_00_00};
    dir_tab[7]  = '{1'b0, 16'd0, 16'hDC00, 1'b1, 3'd4, 48'hF0_90_80_80_00_00};
    dir_tab[8]  = '{1'b0, 16'd0, 16'hDBFF, 1'b1, 3'd0, 48'h00_00_00_00_00_00};
    dir_tab[9]  = '{1'b0, 16'd0, 16'hDFFF, 1'b1, 3'd4, 48'hF4_8F_BF_BF_00_00};
    dir_tab[10] = '{1'b0, 16'd0, 16'hDC00, 1'b1, 3'd3, 48'hED_B0_80_00_00_00};
    dir_tab[11] = '{1'b0, 16'd0, 16'hD83D, 1'b1, 3'd0, 48'h00_00_00_00_00_00};
    dir_tab[12] = '{1'b0, 16'd0, 16'h0041, 1'b0, 3'd0, 48'h00_00_00_00_00_00};
    dir_tab[13] = '{1'b0, 16'd0, 16'hDABC, 1'b1, 3'd0, 48'h00_00_00_00_00_00};
    dir_tab[14] = '{1'b0, 16'd0, 16'hE123, 1'b0, 3'd0, 48'h00_00_00_00_00_00};
    dir_tab[15] = '{1'b0, 16'd0, 16'hD801, 1'b1, 3'd0, 48'h00_00_00_00_00_00};
    dir_tab[16] = '{1'b0, 16'd0, 16'hD802, 1'b0, 3'd0, 48'h00_00_00_00_00_00};
    dir_tab[17] = '{1'b0, 16'd0, 16'h0000, 1'b0, 3'd0, 48'h00_00_00_00_00_00};
    dir_tab[18] = '{1'b1, 16'd4, 16'h0041, 1'b1, 3'd1, 48'h41_00_00_00_00_00};
    dir_tab[19] = '{1'b0, 16'd0, 16'h0080, 1'b1, 3'd2, 48'hC2_80_00_00_00_00};
    dir_tab[20] = '{1'b0, 16'd0, 16'h0042, 1'b1, 3'd0, 48'h00_00_00_00_00_00};
    dir_tab[21] = '{1'b0, 16'd0, 16'hD800, 1'b1, 3'd0, 48'h00_00_00_00_00_00};
    dir_tab[22] = '{1'b0, 16'd0, 16'h0000, 1'b1, 3'd1, 48'h00_00_00_00_00_00};
    dir_tab[23] = '{1'b1, 16'd0, 16'h0041, 1'b1, 3'd0, 48'h00_00_00_00_00_00};
    dir_tab[24] = '{1'b0, 16'd0, 16'h0000, 1'b1, 3'd1, 48'h00_00_00_00_00_00};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at full speed.
    for (r = 0; r < DIR_ROWS; r++) begin
      if (dir_tab[r].set_cap) begin
        wait_drained();
        write_capacity(dir_tab[r].cap);
      end
      send_unit(dir_tab[r].unit, dir_tab[r].typed, dir_tab[r].n, dir_tab[r].bytes);
    end

    // Random phases: mostly well-formed text, some broken surrogates and raw units.
    for (p = 0; p < N_PHASES; p++) begin
      wait_drained();
      if (phase_cap[p] == CAP_RANDOM)
        cap_val = 16'($urandom_range(2, 40));
      else
        cap_val = 16'(phase_cap[p]);
      write_capacity(cap_val);
      idle_pct = (phase_mode[p] == IDLE_BOTH) ? 37 : 63;
      tx_idle = (phase_mode[p] == IDLE_TX) || (phase_mode[p] == IDLE_BOTH);
      rx_stall <= (phase_mode[p] == IDLE_RX) || (phase_mode[p] == IDLE_BOTH);
      start = n_units;
      k = 0;
      while (n_units - start < phase_goal[p]) begin
        // One long receiver hold-off while the sender keeps offering.
        if (p == 3 && k == 6)
          hold_req <= hold_req + 1;
        // Once, the sender pauses until all pending bytes are out.
        if (p == 6 && k == 4)
          wait_drained();
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          send_unit(16'h0000, 1'b0, 0, 48'd0);
        end else if (pick < 37) begin
          u = 16'($urandom_range(16'h0001, 16'h007F));
          send_unit(u, 1'b0, 0, 48'd0);
        end else if (pick < 52) begin
          u = 16'($urandom_range(16'h0080, 16'h07FF));
          send_unit(u, 1'b0, 0, 48'd0);
        end else if (pick < 67) begin
          u = 16'($urandom_range(16'h0800, 16'hFFFF));
          if (u[15:11] == 5'b11011)
            u = u ^ 16'h2000;
          send_unit(u, 1'b0, 0, 48'd0);
        end else if (pick < 85) begin
          u = HIGH_SURR | 16'($urandom_range(0, 1023));
          send_unit(u, 1'b0, 0, 48'd0);
          u = LOW_SURR | 16'($urandom_range(0, 1023));
          send_unit(u, 1'b0, 0, 48'd0);
        end else if (pick < 90) begin
          u = HIGH_SURR | 16'($urandom_range(0, 1023));
          send_unit(u, 1'b0, 0, 48'd0);
        end else if (pick < 95) begin
          u = LOW_SURR | 16'($urandom_range(0, 1023));
          send_unit(u, 1'b0, 0, 48'd0);
        end else begin
          u = 16'($urandom_range(0, 65535));
          send_unit(u, 1'b0, 0, 48'd0);
        end
        k++;
      end
    end

    tx_idle = 1'b0;
    rx_stall <= 1'b0;
    wait_drained();

    $display("Run covered %0d code units (%0d producing output or held)", n_units,
             n_effective);
    $display("and %0d capacity writes, with idle and stalled channels and one long %s %0d.",
             n_cfg, "output hold; bytes checked:", n_checked);
    if (errors == 0 && utf8_expected.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
design/u16u8_pkg.sv
design/u16u8_decode.sv
design/u16u8_serial.sv
design/utf16_to_utf8_transcoder_core.sv
verif/utf16_to_utf8_transcoder_core_tb.sv
